// ===== hw/rtl/buffer_cache_tag_manager_top_defines.svh =====
// assertion macros shared by the rtl files
`ifndef BUFFER_CACHE_TAG_MANAGER_TOP_DEFINES_SVH
`define BUFFER_CACHE_TAG_MANAGER_TOP_DEFINES_SVH

`ifndef SYNTH

`define BCTM_ASSERT_ALWAYS(lbl, clk, rst_n, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (c)) \
        else $error("assertion failed");

`define BCTM_ASSERT_IMPLY(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("assertion failed");

`define BCTM_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("assertion failed");

`else

`define BCTM_ASSERT_ALWAYS(lbl, clk, rst_n, c)
`define BCTM_ASSERT_IMPLY(lbl, clk, rst_n, a, c)
`define BCTM_ASSERT_NEXT(lbl, clk, rst_n, a, c)

`endif

`endif

// ===== hw/rtl/bctm_pkg.sv =====
package bctm_pkg;

    localparam int SLOTS      = 32;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int BLOCK_BITS = 13;
    localparam int AGE_W      = 6;

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [BLOCK_BITS-1:0] t_blk;
    typedef logic [AGE_W-1:0]      t_age;

    localparam t_age AGE_MAX = {AGE_W{1'b1}};

    typedef enum logic [1:0] {
        FN_ALLOC  = 2'd0,
        FN_LOOKUP = 2'd1,
        FN_DIRTY  = 2'd2,
        FN_FLUSH  = 2'd3
    } t_func;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // record carried along the cell row with the scan token
    typedef struct packed {
        logic free_found;
        t_idx free_idx;
        t_idx old_idx;
        t_age old_age;
        logic old_dirty;
        t_blk old_block;
        logic hit;
        t_idx hit_idx;
    } t_rec;

    localparam t_rec REC_INIT = '0;

    // broadcast from control to every cell
    typedef struct packed {
        logic age_inc;
        logic flush;
        logic wr_en;
        logic wr_alloc;
        t_idx wr_idx;
        t_blk blk;
    } t_cmd;

    // flush word offered by a cell
    typedef struct packed {
        logic en;
        t_idx idx;
        t_blk block;
    } t_emit;

endpackage

// ===== hw/rtl/bctm_cell.sv =====
module bctm_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bctm_pkg::t_idx    i_idx,
    input  logic              i_tok,
    input  bctm_pkg::t_rec    i_rec,
    input  bctm_pkg::t_cmd    i_cmd,
    output logic              o_tok,
    output bctm_pkg::t_rec    o_rec,
    output bctm_pkg::t_emit   o_emit
);

    logic           r_valid, n_valid;
    logic           r_dirty, n_dirty;
    bctm_pkg::t_age r_age,   n_age;
    bctm_pkg::t_blk r_block, n_block;
    logic           r_tok;
    bctm_pkg::t_rec r_rec,   n_rec;
    logic           sel;

    assign sel = i_cmd.wr_en && (i_cmd.wr_idx == i_idx);

    always_comb begin
        o_emit.en    = i_tok && i_cmd.flush && r_valid && r_dirty;
        o_emit.idx   = o_emit.en ? i_idx : '0;
        o_emit.block = o_emit.en ? r_block : '0;
    end

    always_comb begin
        n_rec = i_rec;
        if (!i_rec.free_found && !r_valid) begin
            n_rec.free_found = 1'b1;
            n_rec.free_idx   = i_idx;
        end
        if ((i_idx == '0) || (r_age > i_rec.old_age)) begin
            n_rec.old_idx   = i_idx;
            n_rec.old_age   = r_age;
            n_rec.old_dirty = r_dirty;
            n_rec.old_block = r_block;
        end
        if (!i_rec.hit && r_valid && (r_block == i_cmd.blk)) begin
            n_rec.hit     = 1'b1;
            n_rec.hit_idx = i_idx;
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_dirty = r_dirty;
        n_age   = r_age;
        n_block = r_block;
        if (i_cmd.age_inc && r_valid && (r_age != bctm_pkg::AGE_MAX)) begin
            n_age = r_age + 1'b1;
        end
        if (sel) begin
            if (i_cmd.wr_alloc) begin
                n_valid = 1'b1;
                n_dirty = 1'b0;
                n_age   = '0;
                n_block = i_cmd.blk;
            end else begin
                n_dirty = 1'b1;
            end
        end
        if (o_emit.en) begin
            n_dirty = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
            r_age   <= '0;
            r_tok   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_dirty <= n_dirty;
            r_age   <= n_age;
            r_tok   <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_block <= n_block;
        if (i_tok) begin
            r_rec <= n_rec;
        end
    end

    assign o_tok = r_tok;
    assign o_rec = r_rec;

endmodule

// ===== hw/rtl/bctm_ctrl.sv =====
`include "buffer_cache_tag_manager_top_defines.svh"

module bctm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [1:0]        i_func,
    input  bctm_pkg::t_blk    i_block_number,
    input  logic              i_end_tok,
    input  bctm_pkg::t_rec    i_end_rec,
    input  bctm_pkg::t_emit   i_emit,
    output logic              busy,
    output logic              o_launch,
    output bctm_pkg::t_cmd    o_cmd,
    output logic              o_strobe,
    output logic              o_status,
    output bctm_pkg::t_idx    o_slot_index,
    output logic              o_writeback_valid,
    output bctm_pkg::t_blk    o_writeback_block,
    output logic              o_last
);

    bctm_pkg::t_state r_state, n_state;
    bctm_pkg::t_func  r_func;
    bctm_pkg::t_blk   r_blk;
    logic             r_launch;
    logic             r_pend_v, n_pend_v;
    bctm_pkg::t_idx   r_pend_idx, n_pend_idx;
    bctm_pkg::t_blk   r_pend_blk, n_pend_blk;
    logic             r_strobe, n_strobe;
    logic             r_status, n_status;
    bctm_pkg::t_idx   r_idx,    n_idx;
    logic             r_wbv,    n_wbv;
    bctm_pkg::t_blk   r_wbb,    n_wbb;
    logic             r_last,   n_last;
    logic             accept;
    bctm_pkg::t_idx   alloc_idx;
    logic             alloc_wb;

    assign accept    = start && (r_state == bctm_pkg::ST_IDLE);
    assign alloc_idx = i_end_rec.free_found ? i_end_rec.free_idx : i_end_rec.old_idx;
    assign alloc_wb  = !i_end_rec.free_found && i_end_rec.old_dirty;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bctm_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = bctm_pkg::ST_SCAN;
                end
            end
            bctm_pkg::ST_SCAN: begin
                if (i_end_tok) begin
                    n_state = bctm_pkg::ST_IDLE;
                end
            end
            default: n_state = bctm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.age_inc  = accept && (bctm_pkg::t_func'(i_func) == bctm_pkg::FN_ALLOC);
        o_cmd.flush    = (r_func == bctm_pkg::FN_FLUSH);
        o_cmd.wr_alloc = (r_func == bctm_pkg::FN_ALLOC);
        o_cmd.wr_en    = i_end_tok && ((r_func == bctm_pkg::FN_ALLOC) ||
                         ((r_func == bctm_pkg::FN_DIRTY) && i_end_rec.hit));
        o_cmd.wr_idx   = (r_func == bctm_pkg::FN_ALLOC) ? alloc_idx : i_end_rec.hit_idx;
        o_cmd.blk      = r_blk;

        n_strobe   = 1'b0;
        n_status   = 1'b0;
        n_idx      = '0;
        n_wbv      = 1'b0;
        n_wbb      = '0;
        n_last     = 1'b0;
        n_pend_v   = r_pend_v;
        n_pend_idx = r_pend_idx;
        n_pend_blk = r_pend_blk;

        if (accept) begin
            n_pend_v = 1'b0;
        end
        if (i_end_tok) begin
            n_strobe = 1'b1;
            n_last   = 1'b1;
            n_pend_v = 1'b0;
            unique case (r_func) inside
                bctm_pkg::FN_ALLOC: begin
                    n_idx = alloc_idx;
                    n_wbv = alloc_wb;
                    n_wbb = alloc_wb ? i_end_rec.old_block : '0;
                end
                bctm_pkg::FN_LOOKUP, bctm_pkg::FN_DIRTY: begin
                    n_status = !i_end_rec.hit;
                    n_idx    = i_end_rec.hit ? i_end_rec.hit_idx : '0;
                end
                bctm_pkg::FN_FLUSH: begin
                    if (r_pend_v) begin
                        n_idx = r_pend_idx;
                        n_wbv = 1'b1;
                        n_wbb = r_pend_blk;
                    end
                end
                default: n_strobe = 1'b0;
            endcase
        end else if (i_emit.en) begin
            n_strobe   = r_pend_v;
            n_idx      = r_pend_idx;
            n_wbv      = 1'b1;
            n_wbb      = r_pend_blk;
            n_pend_v   = 1'b1;
            n_pend_idx = i_emit.idx;
            n_pend_blk = i_emit.block;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bctm_pkg::ST_IDLE;
            r_launch <= 1'b0;
            r_pend_v <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= accept;
            r_pend_v <= n_pend_v;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= bctm_pkg::t_func'(i_func);
            r_blk  <= i_block_number;
        end
        r_pend_idx <= n_pend_idx;
        r_pend_blk <= n_pend_blk;
        r_status   <= n_status;
        r_idx      <= n_idx;
        r_wbv      <= n_wbv;
        r_wbb      <= n_wbb;
        r_last     <= n_last;
    end

    assign busy              = (r_state != bctm_pkg::ST_IDLE);
    assign o_launch          = r_launch;
    assign o_strobe          = r_strobe;
    assign o_status          = r_status;
    assign o_slot_index      = r_idx;
    assign o_writeback_valid = r_wbv;
    assign o_writeback_block = r_wbb;
    assign o_last            = r_last;

    `BCTM_ASSERT_NEXT(a_end_gives_word, i_clk, i_rst_n, i_end_tok, r_strobe && r_last)
    `BCTM_ASSERT_IMPLY(a_last_idle, i_clk, i_rst_n, r_strobe && r_last, r_state == bctm_pkg::ST_IDLE)
    `BCTM_ASSERT_IMPLY(a_emit_flush, i_clk, i_rst_n, i_emit.en, r_func == bctm_pkg::FN_FLUSH && r_state == bctm_pkg::ST_SCAN)
    `BCTM_ASSERT_IMPLY(a_launch_scan, i_clk, i_rst_n, r_launch, r_state == bctm_pkg::ST_SCAN)

endmodule

// ===== hw/rtl/buffer_cache_tag_manager_top.sv =====
// channel   direction  ports                                                handshake
// request   in         i_func, i_block_number                              start && !busy
// result    out        o_status, o_slot_index, o_writeback_valid,          o_strobe, one cycle
//                      o_writeback_block, o_last
//
// every request runs one scan: one scan token walks the cell row one slot per cycle
// an allocate, lookup or mark dirty gives one word the cycle after the token leaves the last cell
// a flush gives one word per dirty slot, each held until the scan finds the next dirty slot,
// the final one at the end; a flush with no dirty slot gives one word, with no writeback, at the end
// reset is synchronous, active low, and frees every slot at once
// the receiver cannot stall; no word waits on the receiver
`include "buffer_cache_tag_manager_top_defines.svh"

module buffer_cache_tag_manager_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic [1:0]            i_func,
    input  bctm_pkg::t_blk        i_block_number,
    output logic                  busy,
    output logic                  o_strobe,
    output logic                  o_status,
    output bctm_pkg::t_idx        o_slot_index,
    output logic                  o_writeback_valid,
    output bctm_pkg::t_blk        o_writeback_block,
    output logic                  o_last
);

    logic              launch;
    bctm_pkg::t_cmd    cmd;
    logic              tok_in  [bctm_pkg::SLOTS];
    logic              tok_out [bctm_pkg::SLOTS];
    bctm_pkg::t_rec    rec_in  [bctm_pkg::SLOTS];
    bctm_pkg::t_rec    rec_out [bctm_pkg::SLOTS];
    bctm_pkg::t_emit   emit    [bctm_pkg::SLOTS];
    bctm_pkg::t_emit   emit_any;
    logic [bctm_pkg::SLOTS-1:0] tok_vec;

    for (genvar g = 0; g < bctm_pkg::SLOTS; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign tok_in[g] = launch;
            assign rec_in[g] = bctm_pkg::REC_INIT;
        end else begin : g_link
            assign tok_in[g] = tok_out[g-1];
            assign rec_in[g] = rec_out[g-1];
        end

        assign tok_vec[g] = tok_out[g];

        bctm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (bctm_pkg::t_idx'(g)),
            .i_tok   (tok_in[g]),
            .i_rec   (rec_in[g]),
            .i_cmd   (cmd),
            .o_tok   (tok_out[g]),
            .o_rec   (rec_out[g]),
            .o_emit  (emit[g])
        );
    end

    always_comb begin
        emit_any = '0;
        for (int i = 0; i < bctm_pkg::SLOTS; i++) begin
            emit_any = emit_any | emit[i];
        end
    end

    bctm_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .i_func            (i_func),
        .i_block_number    (i_block_number),
        .i_end_tok         (tok_out[bctm_pkg::SLOTS-1]),
        .i_end_rec         (rec_out[bctm_pkg::SLOTS-1]),
        .i_emit            (emit_any),
        .busy              (busy),
        .o_launch          (launch),
        .o_cmd             (cmd),
        .o_strobe          (o_strobe),
        .o_status          (o_status),
        .o_slot_index      (o_slot_index),
        .o_writeback_valid (o_writeback_valid),
        .o_writeback_block (o_writeback_block),
        .o_last            (o_last)
    );

    `BCTM_ASSERT_ALWAYS(a_one_token, i_clk, i_rst_n, $onehot0({tok_vec, launch}))

endmodule
